FILE: hw/rtl/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared constants for the WAV header parser: chunk tags, parse phases and
// status codes.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned FMT_LEN  = 16;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [PHASE_W-1:0]  phase_t;

  // tags as seen in a little-endian shift register
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam phase_t PH_RIFF_TAG   = 3'd0;
  localparam phase_t PH_RIFF_SIZE  = 3'd1;
  localparam phase_t PH_WAVE_TAG   = 3'd2;
  localparam phase_t PH_CHUNK_ID   = 3'd3;
  localparam phase_t PH_CHUNK_SIZE = 3'd4;
  localparam phase_t PH_FMT_BODY   = 3'd5;
  localparam phase_t PH_SKIP       = 3'd6;
  localparam phase_t PH_DONE       = 3'd7;

  localparam status_t ST_PARSING  = 3'd0;
  localparam status_t ST_OK       = 3'd1;
  localparam status_t ST_NOT_RIFF = 3'd2;
  localparam status_t ST_NOT_WAVE = 3'd3;
  localparam status_t ST_NO_FMT   = 3'd4;
  localparam status_t ST_NO_DATA  = 3'd5;

endpackage

FILE: hw/rtl/wavhp_if.sv
// ----------------------------------------------------------------------------
// wavhp_in_if / wavhp_out_if
// Valid/ready channels carrying file bytes in and parse results out.
// ----------------------------------------------------------------------------
interface wavhp_in_if;
  import wavhp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;
  logic              final_byte;

  modport source (output valid, output data_byte, output first_byte,
                  output final_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte,
                  input final_byte, output ready);
endinterface

interface wavhp_out_if;
  import wavhp_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] riff_len;
  logic [15:0] format_code;
  logic [15:0] channel_count;
  logic [31:0] sample_freq;
  logic [31:0] bytes_per_sec;
  logic [15:0] frame_bytes;
  logic [15:0] sample_bits;
  logic [31:0] payload_len;
  logic [31:0] payload_pos;

  modport source (output valid, output status, output riff_len,
                  output format_code, output channel_count, output sample_freq,
                  output bytes_per_sec, output frame_bytes, output sample_bits,
                  output payload_len, output payload_pos, input ready);
  modport sink   (input valid, input status, input riff_len,
                  input format_code, input channel_count, input sample_freq,
                  input bytes_per_sec, input frame_bytes, input sample_bits,
                  input payload_len, input payload_pos, output ready);
endinterface

FILE: hw/rtl/wav_header_parser.sv
// ----------------------------------------------------------------------------
// wav_header_parser
// Byte-serial RIFF/WAVE header parser: checks tags, walks chunks, captures
// the PCM fmt fields and reports the data chunk size and offset.
//
//   channel   dir   payload                                 handshake
//   in_ch     in    data_byte, first_byte, final_byte       valid/ready
//   out_ch    out   status, riff_len, fmt fields,           valid/ready
//                   payload_len, payload_pos
//
// One byte is taken per cycle while out_ch does not stall; each accepted
// byte yields one result word in the next cycle, from the output register.
// The parse state is updated in a single pass at the input handshake.
// in_ch.ready stays high while the output register is empty or being taken.
// Synchronous active-low reset clears all parse state and the output valid.
// ----------------------------------------------------------------------------
module wav_header_parser (
  input logic  clk,
  input logic  rst_n,
  wavhp_in_if.sink    in_ch,
  wavhp_out_if.source out_ch
);
  import wavhp_pkg::*;

  phase_t            phase_r,    phase_nxt;
  logic [IDX_W-1:0]  idx_r,      idx_nxt;
  logic [31:0]       tag_r,      tag_nxt;
  logic [31:0]       len_r,      len_nxt;
  logic [32:0]       skip_r,     skip_nxt;
  logic [31:0]       pos_r,      pos_nxt;
  logic              fmt_seen_r, fmt_seen_nxt;
  logic [7:0]        fmt_r       [FMT_LEN];
  logic [7:0]        fmt_nxt     [FMT_LEN];
  logic [31:0]       fsize_r,    fsize_nxt;
  logic [31:0]       dsize_r,    dsize_nxt;
  logic [31:0]       doff_r,     doff_nxt;
  status_t           status_r,   status_nxt;
  logic              out_valid_r;

  logic              accept;
  logic [IDX_W-1:0]  idx_inc;
  logic [IDX_W-1:0]  cap;
  logic [31:0]       len_sh;
  logic [31:0]       tag_sh;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_ch.first_byte) begin
      phase_nxt    = PH_RIFF_TAG;
      idx_nxt      = '0;
      tag_nxt      = '0;
      len_nxt      = '0;
      skip_nxt     = '0;
      pos_nxt      = '0;
      fmt_seen_nxt = 1'b0;
      fmt_nxt      = '{default: '0};
      fsize_nxt    = '0;
      dsize_nxt    = '0;
      doff_nxt     = '0;
      status_nxt   = ST_PARSING;
    end else begin
      phase_nxt    = phase_r;
      idx_nxt      = idx_r;
      tag_nxt      = tag_r;
      len_nxt      = len_r;
      skip_nxt     = skip_r;
      pos_nxt      = pos_r;
      fmt_seen_nxt = fmt_seen_r;
      fmt_nxt      = fmt_r;
      fsize_nxt    = fsize_r;
      dsize_nxt    = dsize_r;
      doff_nxt     = doff_r;
      status_nxt   = status_r;
    end

    idx_inc = idx_nxt + 5'd1;
    tag_sh  = {in_ch.data_byte, tag_nxt[31:8]};
    len_sh  = {in_ch.data_byte, len_nxt[31:8]};
    cap     = (len_nxt < 32'd16) ? len_nxt[IDX_W-1:0] : 5'd16;

    if (status_nxt == ST_PARSING) begin
      pos_nxt = pos_nxt + 32'd1;
      case (phase_nxt)
        PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
          tag_nxt = tag_sh;
          idx_nxt = idx_inc;
          if (idx_inc == 5'd4) begin
            idx_nxt = '0;
            if (phase_nxt == PH_RIFF_TAG) begin
              if (tag_sh != TAG_RIFF) begin
                status_nxt = ST_NOT_RIFF;
                phase_nxt  = PH_DONE;
              end else begin
                phase_nxt = PH_RIFF_SIZE;
              end
            end else if (phase_nxt == PH_WAVE_TAG) begin
              if (tag_sh != TAG_WAVE) begin
                status_nxt = ST_NOT_WAVE;
                phase_nxt  = PH_DONE;
              end else begin
                phase_nxt = PH_CHUNK_ID;
              end
            end else begin
              phase_nxt = PH_CHUNK_SIZE;
            end
          end
        end
        PH_RIFF_SIZE: begin
          len_nxt = len_sh;
          idx_nxt = idx_inc;
          if (idx_inc == 5'd4) begin
            idx_nxt   = '0;
            fsize_nxt = len_sh;
            phase_nxt = PH_WAVE_TAG;
          end
        end
        PH_CHUNK_SIZE: begin
          len_nxt = len_sh;
          idx_nxt = idx_inc;
          cap     = (len_sh < 32'd16) ? len_sh[IDX_W-1:0] : 5'd16;
          if (idx_inc == 5'd4) begin
            idx_nxt = '0;
            if (tag_nxt == TAG_FMT) begin
              fmt_nxt  = '{default: '0};
              skip_nxt = {1'b0, len_sh - {27'd0, cap}} + {32'd0, len_sh[0]};
              if (cap == '0) begin
                phase_nxt = (skip_nxt != '0) ? PH_SKIP : PH_CHUNK_ID;
              end else begin
                phase_nxt = PH_FMT_BODY;
              end
            end else if (tag_nxt == TAG_DATA) begin
              if (fmt_seen_nxt) begin
                dsize_nxt  = len_sh;
                doff_nxt   = pos_nxt;
                status_nxt = ST_OK;
              end else begin
                status_nxt = ST_NO_FMT;
              end
              phase_nxt = PH_DONE;
            end else begin
              skip_nxt  = {1'b0, len_sh} + {32'd0, len_sh[0]};
              phase_nxt = (skip_nxt != '0) ? PH_SKIP : PH_CHUNK_ID;
            end
          end
        end
        PH_FMT_BODY: begin
          fmt_nxt[idx_nxt[3:0]] = in_ch.data_byte;
          idx_nxt = idx_inc;
          if (idx_inc >= cap) begin
            fmt_seen_nxt = 1'b1;
            idx_nxt      = '0;
            phase_nxt    = (skip_nxt != '0) ? PH_SKIP : PH_CHUNK_ID;
          end
        end
        PH_SKIP: begin
          if (skip_nxt != '0) begin
            skip_nxt = skip_nxt - 33'd1;
          end
          if (skip_nxt == '0) begin
            phase_nxt = PH_CHUNK_ID;
          end
        end
        default: begin
        end
      endcase

      if (status_nxt == ST_PARSING && in_ch.final_byte) begin
        if (phase_nxt == PH_RIFF_TAG) begin
          status_nxt = ST_NOT_RIFF;
        end else if (phase_nxt == PH_RIFF_SIZE || phase_nxt == PH_WAVE_TAG) begin
          status_nxt = ST_NOT_WAVE;
        end else begin
          status_nxt = fmt_seen_nxt ? ST_NO_DATA : ST_NO_FMT;
        end
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF_TAG;
      idx_r       <= '0;
      tag_r       <= '0;
      len_r       <= '0;
      skip_r      <= '0;
      pos_r       <= '0;
      fmt_seen_r  <= 1'b0;
      fmt_r       <= '{default: '0};
      fsize_r     <= '0;
      dsize_r     <= '0;
      doff_r      <= '0;
      status_r    <= ST_PARSING;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        idx_r      <= idx_nxt;
        tag_r      <= tag_nxt;
        len_r      <= len_nxt;
        skip_r     <= skip_nxt;
        pos_r      <= pos_nxt;
        fmt_seen_r <= fmt_seen_nxt;
        fmt_r      <= fmt_nxt;
        fsize_r    <= fsize_nxt;
        dsize_r    <= dsize_nxt;
        doff_r     <= doff_nxt;
        status_r   <= status_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word is read straight from the committed state
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.riff_len      = fsize_r;
  assign out_ch.format_code   = {fmt_r[1], fmt_r[0]};
  assign out_ch.channel_count = {fmt_r[3], fmt_r[2]};
  assign out_ch.sample_freq   = {fmt_r[7], fmt_r[6], fmt_r[5], fmt_r[4]};
  assign out_ch.bytes_per_sec = {fmt_r[11], fmt_r[10], fmt_r[9], fmt_r[8]};
  assign out_ch.frame_bytes   = {fmt_r[13], fmt_r[12]};
  assign out_ch.sample_bits   = {fmt_r[15], fmt_r[14]};
  assign out_ch.payload_len   = dsize_r;
  assign out_ch.payload_pos   = doff_r;

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for wav_header_parser. A behavioural parser follows
// the byte stream and predicts each result word, which is checked field by
// field. Directed files cover tag errors, early stream ends, data before fmt,
// short, empty, oversized and repeated fmt chunks, padded chunks and restarts.
// Random WAV files with corruption and noise follow, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wavhp_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] riff_len;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_freq;
    logic [31:0] bytes_per_sec;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
    logic [31:0] payload_len;
    logic [31:0] payload_pos;
  } wav_report_t;

  typedef struct {
    logic [7:0] value;
    bit         first;
    bit         last;
    bit         drain;
  } stream_byte_t;

  logic clk;
  logic rst_n;

  wavhp_in_if  in_bus ();
  wavhp_out_if out_bus ();

  wav_header_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  stream_byte_t file_byte_q[$];
  wav_report_t  report_q[$];
  logic [7:0]   file_q[$];

  int unsigned sent_bytes;
  int unsigned file_count;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned status_hits[8];

  // parser state
  phase_t      p_phase;
  logic [4:0]  p_idx;
  logic [31:0] p_tag;
  logic [31:0] p_len;
  logic [32:0] p_skip;
  logic [31:0] p_pos;
  bit          p_fmt_ok;
  logic [7:0]  p_fmt[16];
  logic [31:0] p_riff_len;
  logic [31:0] p_payload_len;
  logic [31:0] p_payload_pos;
  status_t     p_status;

  function void parser_clear();
    p_phase       = PH_RIFF_TAG;
    p_idx         = '0;
    p_tag         = '0;
    p_len         = '0;
    p_skip        = '0;
    p_pos         = '0;
    p_fmt_ok      = 1'b0;
    p_riff_len    = '0;
    p_payload_len = '0;
    p_payload_pos = '0;
    p_status      = ST_PARSING;
    foreach (p_fmt[i]) p_fmt[i] = '0;
  endfunction

  function logic [31:0] fmt_span();
    return (p_len < 32'd16) ? p_len : 32'd16;
  endfunction

  function void body_done();
    p_idx   = '0;
    p_phase = (p_skip != 0) ? PH_SKIP : PH_CHUNK_ID;
  endfunction

  function void chunk_header_done();
    logic [31:0] span;
    span  = fmt_span();
    p_idx = '0;
    if (p_tag == TAG_FMT) begin
      foreach (p_fmt[i]) p_fmt[i] = '0;
      p_skip = {1'b0, p_len - span} + 33'(p_len[0]);
      if (span == 0) body_done();
      else p_phase = PH_FMT_BODY;
    end else if (p_tag == TAG_DATA) begin
      if (p_fmt_ok) begin
        p_payload_len = p_len;
        p_payload_pos = p_pos;
        p_status      = ST_OK;
      end else begin
        p_status = ST_NO_FMT;
      end
      p_phase = PH_DONE;
    end else begin
      p_skip = {1'b0, p_len} + 33'(p_len[0]);
      body_done();
    end
  endfunction

  function void take_byte(logic [7:0] b);
    case (p_phase)
      PH_RIFF_TAG: begin
        p_tag = {b, p_tag[31:8]};
        p_idx++;
        if (p_idx == 4) begin
          p_idx = '0;
          if (p_tag != TAG_RIFF) begin
            p_status = ST_NOT_RIFF;
            p_phase  = PH_DONE;
          end else begin
            p_phase = PH_RIFF_SIZE;
          end
        end
      end
      PH_RIFF_SIZE: begin
        p_len = {b, p_len[31:8]};
        p_idx++;
        if (p_idx == 4) begin
          p_idx      = '0;
          p_riff_len = p_len;
          p_phase    = PH_WAVE_TAG;
        end
      end
      PH_WAVE_TAG: begin
        p_tag = {b, p_tag[31:8]};
        p_idx++;
        if (p_idx == 4) begin
          p_idx = '0;
          if (p_tag != TAG_WAVE) begin
            p_status = ST_NOT_WAVE;
            p_phase  = PH_DONE;
          end else begin
            p_phase = PH_CHUNK_ID;
          end
        end
      end
      PH_CHUNK_ID: begin
        p_tag = {b, p_tag[31:8]};
        p_idx++;
        if (p_idx == 4) begin
          p_idx   = '0;
          p_phase = PH_CHUNK_SIZE;
        end
      end
      PH_CHUNK_SIZE: begin
        p_len = {b, p_len[31:8]};
        p_idx++;
        if (p_idx == 4) chunk_header_done();
      end
      PH_FMT_BODY: begin
        p_fmt[p_idx[3:0]] = b;
        p_idx++;
        if ({27'd0, p_idx} >= fmt_span()) begin
          p_fmt_ok = 1'b1;
          body_done();
        end
      end
      PH_SKIP: begin
        if (p_skip != 0) p_skip--;
        if (p_skip == 0) p_phase = PH_CHUNK_ID;
      end
      default: ;
    endcase
  endfunction

  function wav_report_t wav_parse_byte(logic [7:0] b, bit first, bit last);
    wav_report_t r;
    if (first) parser_clear();
    if (p_status == ST_PARSING) begin
      p_pos++;
      take_byte(b);
      if (p_status == ST_PARSING && last) begin
        if (p_phase == PH_RIFF_TAG) p_status = ST_NOT_RIFF;
        else if (p_phase == PH_RIFF_SIZE || p_phase == PH_WAVE_TAG) p_status = ST_NOT_WAVE;
        else p_status = p_fmt_ok ? ST_NO_DATA : ST_NO_FMT;
        p_phase = PH_DONE;
      end
    end
    r.status        = p_status;
    r.riff_len      = p_riff_len;
    r.format_code   = {p_fmt[1], p_fmt[0]};
    r.channel_count = {p_fmt[3], p_fmt[2]};
    r.sample_freq   = {p_fmt[7], p_fmt[6], p_fmt[5], p_fmt[4]};
    r.bytes_per_sec = {p_fmt[11], p_fmt[10], p_fmt[9], p_fmt[8]};
    r.frame_bytes   = {p_fmt[13], p_fmt[12]};
    r.sample_bits   = {p_fmt[15], p_fmt[14]};
    r.payload_len   = p_payload_len;
    r.payload_pos   = p_payload_pos;
    return r;
  endfunction

  // stimulus helpers
  function bit pct(int unsigned n);
    return $urandom_range(0, 99) < n;
  endfunction

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function int unsigned rand_size();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function int unsigned fmt_size();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16;
    if (r == 6) return 18;
    if (r == 7) return 40;
    return $urandom_range(0, 20);
  endfunction

  function void push_stream(logic [7:0] v, bit first, bit last, bit drain);
    stream_byte_t s;
    s.value = v;
    s.first = first;
    s.last  = last;
    s.drain = drain;
    file_byte_q.push_back(s);
    sent_bytes++;
  endfunction

  function void put8(int unsigned v);
    file_q.push_back(v[7:0]);
  endfunction

  function void put16(int unsigned v);
    put8(v);
    put8(v >> 8);
  endfunction

  function void put32(int unsigned v);
    put16(v);
    put16(v >> 16);
  endfunction

  function void put_chunk_head(logic [31:0] tag, int unsigned size);
    put32(tag);
    put32(size);
  endfunction

  function void put_riff(int unsigned size, bit bad_riff, bit bad_wave);
    put32(bad_riff ? TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)) : TAG_RIFF);
    put32(size);
    put32(bad_wave ? TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)) : TAG_WAVE);
  endfunction

  function void put_fmt(int unsigned size, bit ones);
    put_chunk_head(TAG_FMT, size);
    for (int unsigned i = 0; i < size; i++) put8((ones && i < 16) ? 8'hFF : $urandom);
    if (size[0]) put8($urandom);
  endfunction

  function void put_other_chunk(logic [31:0] tag, int unsigned size);
    put_chunk_head(tag, size);
    repeat (size) put8($urandom);
    if (size[0]) put8($urandom);
  endfunction

  function void put_pcm_wav(int unsigned data_len);
    put_riff(36 + data_len, 1'b0, 1'b0);
    put_chunk_head(TAG_FMT, 16);
    put16(1);
    put16(2);
    put32(44100);
    put32(176400);
    put16(4);
    put16(16);
    put_chunk_head(TAG_DATA, data_len);
  endfunction

  // sends the first cut bytes of the built file, cut < 0 meaning all of it
  function void send_file(int cut, bit last, bit drain);
    int unsigned n;
    n = (cut < 0 || cut > file_q.size()) ? file_q.size() : cut;
    for (int unsigned i = 0; i < n; i++)
      push_stream(file_q[i], i == 0, last && i == n - 1, drain && i == 0);
    file_q.delete();
    file_count++;
  endfunction

  function void send_noise(int unsigned n);
    repeat (n) push_stream(8'($urandom), pct(12), pct(12), 1'b0);
  endfunction

  function void send_tail();
    repeat ($urandom_range(1, 4)) push_stream(8'($urandom), 1'b0, pct(30), 1'b0);
  endfunction

  function void build_directed();
    int cuts[6];
    cuts = '{2, 6, 10, 12, 18, 36};
    put_pcm_wav(0);
    send_file(-1, 1'b0, 1'b1);
    send_tail();
    put_riff(4, 1'b1, 1'b0);
    send_file(-1, 1'b0, 1'b0);
    put_riff(4, 1'b0, 1'b1);
    send_file(-1, 1'b0, 1'b0);
    // stream ends inside each early phase
    foreach (cuts[k]) begin
      put_pcm_wav(8);
      send_file(cuts[k], 1'b1, 1'b0);
    end
    // restart in the middle of a file
    put_pcm_wav(8);
    send_file(20, 1'b0, 1'b0);
    // data before fmt
    put_riff(12, 1'b0, 1'b0);
    put_chunk_head(TAG_DATA, 100);
    send_file(-1, 1'b0, 1'b0);
    // short fmt, then empty fmt
    put_riff(50, 1'b0, 1'b0);
    put_fmt(5, 1'b0);
    put_chunk_head(TAG_DATA, 7);
    send_file(-1, 1'b0, 1'b0);
    put_riff(50, 1'b0, 1'b0);
    put_fmt(0, 1'b0);
    put_chunk_head(TAG_DATA, 7);
    send_file(-1, 1'b1, 1'b0);
    // repeated fmt
    put_riff(32'hFFFF_FFFF, 1'b0, 1'b0);
    put_fmt(16, 1'b1);
    put_fmt(3, 1'b0);
    put_chunk_head(TAG_DATA, 32'hFFFF_FFFF);
    send_file(-1, 1'b0, 1'b1);
    // odd chunks with pad bytes
    put_riff(0, 1'b0, 1'b0);
    put_other_chunk(32'h5453_494C, 3);
    put_fmt(19, 1'b1);
    put_other_chunk($urandom, 0);
    put_other_chunk($urandom, 1);
    put_chunk_head(TAG_DATA, 32'hFFFF_FFFF);
    send_file(-1, 1'b0, 1'b0);
    // huge chunk and huge fmt, stream cut short
    put_riff(1000, 1'b0, 1'b0);
    put_fmt(16, 1'b0);
    put_chunk_head($urandom, 32'hFFFF_FFFF);
    repeat (20) put8($urandom);
    send_file(-1, 1'b1, 1'b0);
    put_riff(1000, 1'b0, 1'b0);
    put_chunk_head(TAG_FMT, 32'hFFFF_FFFF);
    repeat (30) put8($urandom);
    send_file(-1, 1'b1, 1'b0);
  endfunction

  function void build_random_file();
    int unsigned cut;
    put_riff(rand_size(), pct(3), pct(3));
    repeat ($urandom_range(0, 2)) put_other_chunk($urandom, $urandom_range(0, 9));
    if (pct(90)) put_fmt(fmt_size(), pct(10));
    if (pct(10)) put_fmt(fmt_size(), 1'b0);
    repeat ($urandom_range(0, 1)) put_other_chunk($urandom, $urandom_range(0, 9));
    if (pct(90)) put_chunk_head(TAG_DATA, rand_size());
    cut = pct(20) ? $urandom_range(1, file_q.size()) : file_q.size();
    send_file(cut, pct(70), pct(10));
    if (pct(30)) send_tail();
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch: %s at word %0d, got %h, expected %h", what, words_checked, got, want);
  endtask

  task check_report();
    wav_report_t got;
    wav_report_t want;
    got.status        = out_bus.status;
    got.riff_len      = out_bus.riff_len;
    got.format_code   = out_bus.format_code;
    got.channel_count = out_bus.channel_count;
    got.sample_freq   = out_bus.sample_freq;
    got.bytes_per_sec = out_bus.bytes_per_sec;
    got.frame_bytes   = out_bus.frame_bytes;
    got.sample_bits   = out_bus.sample_bits;
    got.payload_len   = out_bus.payload_len;
    got.payload_pos   = out_bus.payload_pos;
    words_checked++;
    if (report_q.size() == 0) begin
      report_mismatch("word with none expected", 32'(got.status), 32'(ST_PARSING));
    end else begin
      want = report_q.pop_front();
      status_hits[want.status]++;
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.riff_len !== want.riff_len)
        report_mismatch("riff_len", got.riff_len, want.riff_len);
      if (got.format_code !== want.format_code)
        report_mismatch("format_code", 32'(got.format_code), 32'(want.format_code));
      if (got.channel_count !== want.channel_count)
        report_mismatch("channel_count", 32'(got.channel_count), 32'(want.channel_count));
      if (got.sample_freq !== want.sample_freq)
        report_mismatch("sample_freq", got.sample_freq, want.sample_freq);
      if (got.bytes_per_sec !== want.bytes_per_sec)
        report_mismatch("bytes_per_sec", got.bytes_per_sec, want.bytes_per_sec);
      if (got.frame_bytes !== want.frame_bytes)
        report_mismatch("frame_bytes", 32'(got.frame_bytes), 32'(want.frame_bytes));
      if (got.sample_bits !== want.sample_bits)
        report_mismatch("sample_bits", 32'(got.sample_bits), 32'(want.sample_bits));
      if (got.payload_len !== want.payload_len)
        report_mismatch("payload_len", got.payload_len, want.payload_len);
      if (got.payload_pos !== want.payload_pos)
        report_mismatch("payload_pos", got.payload_pos, want.payload_pos);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // byte driver
  stream_byte_t next_byte;
  int unsigned  in_gap;
  bit           in_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        report_q.push_back(wav_parse_byte(in_bus.data_byte, in_bus.first_byte,
                                          in_bus.final_byte));
        if (pct(1)) in_calm = !in_calm;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (file_byte_q.size() == 0 ||
                     (file_byte_q[0].drain && report_q.size() != 0)) begin
          in_bus.valid <= 1'b0;
        end else begin
          next_byte = file_byte_q.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.data_byte  <= next_byte.value;
          in_bus.first_byte <= next_byte.first;
          in_bus.final_byte <= next_byte.last;
          in_gap = in_calm ? 0 : gap_len();
        end
      end
    end
  end

  // result monitor
  int unsigned out_stall;
  bit          out_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_report();
      if (out_stall != 0) begin
        out_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (!out_calm && pct(25)) out_stall = gap_len();
        if (pct(1)) out_calm = !out_calm;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = '0;
    in_bus.first_byte = 1'b0;
    in_bus.final_byte = 1'b0;
    out_bus.ready     = 1'b0;
    in_calm           = 1'b0;
    out_calm          = 1'b0;
    parser_clear();
    build_directed();
    while (sent_bytes < 800) begin
      if (pct(5)) send_noise($urandom_range(1, 10));
      else build_random_file();
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (file_byte_q.size() != 0 || in_bus.valid || report_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d bytes in %0d files plus noise, checked %0d result words",
             sent_bytes, file_count, words_checked);
    $display("words by status: parsing %0d, ok %0d, not riff %0d, not wave %0d,",
             status_hits[ST_PARSING], status_hits[ST_OK], status_hits[ST_NOT_RIFF],
             status_hits[ST_NOT_WAVE], " no fmt %0d, no data %0d",
             status_hits[ST_NO_FMT], status_hits[ST_NO_DATA]);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d words still expected", report_q.size());
    $display("tb failed");
    $finish;
  end

endmodule
